[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define AST_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that an expression is never true on a rising clock edge outside reset.
`define AST_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

[rtl/core/bgd_pkg.sv]
// Types and constants shared by the button gesture decoder modules.
package bgd_pkg;

	// Operation carried by an input transaction.
	typedef enum logic [2:0] {
		OP_POLL  = 3'd0,
		OP_NEXT  = 3'd1,
		OP_PREV  = 3'd2,
		OP_TAP   = 3'd3,
		OP_LONG  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	// Event codes as delivered on the result channel and held in the queue.
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_NEXT   = 3'd1,
		EV_PREV   = 3'd2,
		EV_SELECT = 3'd3,
		EV_DOUBLE = 3'd4,
		EV_LONG   = 3'd5
	} ev_t;

	// Button phase of the gesture state machine.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_COMBO = 3'd2,
		PH_DONE  = 3'd3,
		PH_NEXT  = 3'd4,
		PH_PREV  = 3'd5
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DIRECT_MODE     = 3'd0,
		REG_DOUBLE_TAP      = 3'd1,
		REG_LONG_PRESS      = 3'd2,
		REG_COMBO_TOLERANCE = 3'd3,
		REG_REPEAT_INITIAL  = 3'd4,
		REG_REPEAT_INTERVAL = 3'd5
	} reg_idx_t;

	localparam logic [15:0] DOUBLE_TAP_RESET      = 16'd400;
	localparam logic [15:0] LONG_PRESS_RESET      = 16'd1000;
	localparam logic [15:0] COMBO_TOLERANCE_RESET = 16'd150;
	localparam logic [15:0] REPEAT_INITIAL_RESET  = 16'd400;
	localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd150;

	typedef struct packed {
		logic        direct_mode;
		logic [15:0] double_tap_window;
		logic [15:0] long_press_time;
		logic [15:0] combo_tolerance;
		logic [15:0] repeat_initial;
		logic [15:0] repeat_interval;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] time_ms;
		logic        next_level;
		logic        prev_level;
		logic        next_press;
		logic        prev_press;
	} item_t;

	// Command from the gesture engine to the event queue.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		ev_t  code;
	} q_cmd_t;

endpackage

[rtl/core/bgd_ram.sv]
// Generic single-port-write, registered-read RAM.
module bgd_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bgd_queue.sv]
// Event FIFO: pointers, fill count, RAM and a bypass for a head written last cycle.
module bgd_queue #(
	parameter int DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bgd_pkg::q_cmd_t                    cmd,
	output logic [2:0]                         head,
	output logic                               empty,
	output logic [$clog2(DEPTH+1)-1:0]         count_nxt
);
	import bgd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             push_ok;
	logic             byp_q;
	logic [2:0]       byp_data_q;
	logic [2:0]       ram_rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// A new event is dropped when the queue is full.
	assign push_ok = cmd.push && (count_q != CNT_W'(DEPTH));

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		count_d  = count_q;
		if (cmd.clear) begin
			rd_ptr_d = '0;
			wr_ptr_d = '0;
			count_d  = '0;
		end else begin
			if (push_ok) begin
				wr_ptr_d = ptr_inc(wr_ptr_q);
				count_d  = count_q + CNT_W'(1);
			end
			if (cmd.pop) begin
				rd_ptr_d = ptr_inc(rd_ptr_q);
				count_d  = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			byp_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			count_q  <= count_d;
			byp_q    <= push_ok && (wr_ptr_q == rd_ptr_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= cmd.code;
	end

	// The RAM always reads the entry that will be the head in the next cycle.
	bgd_ram #(
		.WIDTH(3),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(wr_ptr_q),
		.wdata(cmd.code),
		.raddr(rd_ptr_d),
		.rdata(ram_rdata)
	);

	assign head      = byp_q ? byp_data_q : ram_rdata;
	assign empty     = (count_q == '0);
	assign count_nxt = count_d;

endmodule

[rtl/core/bgd_engine.sv]
// Gesture engine: button phase machine, tap detector, edge latches and queue commands.
module bgd_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  bgd_pkg::item_t  item,
	input  bgd_pkg::cfg_t   cfg,
	input  logic            mode_flip,
	input  logic            q_empty,
	input  logic [2:0]      q_head,
	output bgd_pkg::q_cmd_t q_cmd,
	output logic [2:0]      res_code,
	output logic            res_beep
);
	import bgd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] start_q, start_d, last_q, last_d, tap_time_q, tap_time_d;
	logic        won_q, won_d, tp_q, tp_d;
	logic        nlat_q, nlat_d, plat_q, plat_d;

	op_t         op;
	logic [31:0] now, el_start, el_last, el_tap, rep_thr;
	logic        nl, pl, both, nel, pel, do_step;
	logic        combo_to, long_hit, rep_hit, tap_in_win;
	ev_t         e_step, tap_ev, to_ev, step_ev;
	logic        long_step, tap_step, tap_req, long_req;

	assign op       = op_t'(item.op);
	assign now      = item.time_ms;
	assign nl       = item.next_level;
	assign pl       = item.prev_level;
	assign both     = nl && pl;
	assign nel      = nlat_q || item.next_press;
	assign pel      = plat_q || item.prev_press;
	assign do_step  = (op == OP_POLL) && q_empty;

	// Elapsed times wrap modulo 2^32.
	assign el_start   = now - start_q;
	assign el_last    = now - last_q;
	assign el_tap     = now - tap_time_q;
	assign rep_thr    = (last_q == start_q) ? {16'b0, cfg.repeat_initial}
	                                        : {16'b0, cfg.repeat_interval};
	assign combo_to   = el_start >= {16'b0, cfg.combo_tolerance};
	assign long_hit   = el_start >= {16'b0, cfg.long_press_time};
	assign rep_hit    = el_last >= rep_thr;
	assign tap_in_win = el_tap <= {16'b0, cfg.double_tap_window};

	// Next state of the button phase machine.
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		last_d  = last_q;
		won_d   = won_q;
		nlat_d  = nel;
		plat_d  = pel;
		if (do_step) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (both) begin
						phase_d = PH_COMBO;
						start_d = now;
						nlat_d  = 1'b0;
						plat_d  = 1'b0;
					end else if (won_q && !nl) begin
						phase_d = PH_IDLE;
						nlat_d  = 1'b0;
					end else if (!won_q && !pl) begin
						phase_d = PH_IDLE;
						plat_d  = 1'b0;
					end else if (combo_to) begin
						phase_d = won_q ? PH_NEXT : PH_PREV;
						start_d = now;
						last_d  = now;
					end
				end
				PH_COMBO: begin
					if (!both) begin
						phase_d = PH_IDLE;
						nlat_d  = 1'b0;
						plat_d  = 1'b0;
					end else if (long_hit) begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
					if (!both) begin
						phase_d = PH_IDLE;
						nlat_d  = 1'b0;
						plat_d  = 1'b0;
					end
				end
				PH_NEXT: begin
					if (!nl) begin
						phase_d = PH_IDLE;
					end else if (rep_hit) begin
						last_d = now;
					end
				end
				PH_PREV: begin
					if (!pl) begin
						phase_d = PH_IDLE;
					end else if (rep_hit) begin
						last_d = now;
					end
				end
				default: begin
					// Idle, and the unused codes, which behave as idle.
					phase_d = PH_IDLE;
					nlat_d  = 1'b0;
					plat_d  = 1'b0;
					if (nel && pel) begin
						phase_d = PH_COMBO;
						start_d = now;
					end else if (nel || pel) begin
						phase_d = PH_WAIT;
						won_d   = nel;
						start_d = now;
					end
				end
			endcase
		end
	end

	// Events produced by the button phase machine.
	always_comb begin
		e_step    = EV_NONE;
		long_step = 1'b0;
		tap_step  = 1'b0;
		if (do_step) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (both) begin
						e_step = EV_NONE;
					end else if (won_q && !nl) begin
						e_step = EV_NEXT;
					end else if (!won_q && !pl) begin
						e_step = EV_PREV;
					end else if (combo_to) begin
						e_step = won_q ? EV_NEXT : EV_PREV;
					end
				end
				PH_COMBO: begin
					if (!both) begin
						tap_step = 1'b1;
					end else if (long_hit) begin
						long_step = 1'b1;
						e_step    = EV_LONG;
					end
				end
				PH_NEXT: begin
					if (nl && rep_hit) begin
						e_step = EV_NEXT;
					end
				end
				PH_PREV: begin
					if (pl && rep_hit) begin
						e_step = EV_PREV;
					end
				end
				default: begin
					e_step = EV_NONE;
				end
			endcase
		end
	end

	assign tap_req  = tap_step || (op == OP_TAP);
	assign long_req = long_step || (op == OP_LONG);

	// Tap detector: double-tap window, timeout and clearing.
	always_comb begin
		tap_ev     = EV_NONE;
		to_ev      = EV_NONE;
		tp_d       = tp_q;
		tap_time_d = tap_time_q;
		if (tap_req) begin
			if (cfg.direct_mode) begin
				tap_ev = EV_SELECT;
			end else if (tp_q && tap_in_win) begin
				tp_d   = 1'b0;
				tap_ev = EV_DOUBLE;
			end else begin
				tp_d       = 1'b1;
				tap_time_d = now;
			end
		end
		if (long_req || (op == OP_CLEAR)) begin
			tp_d = 1'b0;
		end
		// The timeout sees the registered tap state, and is skipped on a tap outside direct mode or a long select.
		if (do_step && !(tap_req && !cfg.direct_mode) && !long_req && tp_q && !tap_in_win) begin
			tp_d  = 1'b0;
			to_ev = EV_SELECT;
		end
	end

	assign step_ev = (e_step != EV_NONE) ? e_step : tap_ev;

	// Queue commands and the result of the transaction.
	always_comb begin
		q_cmd    = '{push: 1'b0, pop: 1'b0, clear: 1'b0, code: EV_NONE};
		res_code = EV_NONE;
		unique case (op)
			OP_POLL: begin
				if (!q_empty) begin
					q_cmd.pop = 1'b1;
					res_code  = q_head;
				end else begin
					// Two events at once: the first goes out, the second is queued.
					res_code   = (step_ev != EV_NONE) ? step_ev : to_ev;
					q_cmd.push = (step_ev != EV_NONE) && (to_ev != EV_NONE);
					q_cmd.code = to_ev;
				end
			end
			OP_NEXT: begin
				q_cmd.push = 1'b1;
				q_cmd.code = EV_NEXT;
			end
			OP_PREV: begin
				q_cmd.push = 1'b1;
				q_cmd.code = EV_PREV;
			end
			OP_TAP: begin
				q_cmd.push = (tap_ev != EV_NONE);
				q_cmd.code = tap_ev;
			end
			OP_LONG: begin
				q_cmd.push = 1'b1;
				q_cmd.code = EV_LONG;
			end
			OP_CLEAR: begin
				q_cmd.clear = 1'b1;
			end
			default: begin
				res_code = EV_NONE;
			end
		endcase
		if (!fire) begin
			q_cmd.push  = 1'b0;
			q_cmd.pop   = 1'b0;
			q_cmd.clear = 1'b0;
		end
	end

	assign res_beep = long_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			start_q    <= '0;
			last_q     <= '0;
			won_q      <= 1'b0;
			nlat_q     <= 1'b0;
			plat_q     <= 1'b0;
			tp_q       <= 1'b0;
			tap_time_q <= '0;
		end else begin
			if (fire) begin
				phase_q    <= phase_d;
				start_q    <= start_d;
				last_q     <= last_d;
				won_q      <= won_d;
				nlat_q     <= nlat_d;
				plat_q     <= plat_d;
				tap_time_q <= tap_time_d;
			end
			if (mode_flip) begin
				tp_q <= 1'b0;
			end else if (fire) begin
				tp_q <= tp_d;
			end
		end
	end

endmodule

[rtl/core/button_gesture_decoder_core.sv]
// Top level of the two-button gesture decoder: handshakes, configuration and result register.
//
// The decoder turns the next and prev buttons into next, prev, select, double-select and
// long-select events. Each input transaction is a poll with a millisecond timestamp, the
// held levels and the press edges seen since the previous transaction, or an injected
// event, or a queue reset. Every input transaction yields exactly one result transaction
// carrying an event code (none when there is nothing to report), a beep pulse on a long
// select, and the number of events still queued. A poll returns the oldest queued event
// if there is one; only a poll that finds the queue empty advances the button machine;
// injected taps, long selects and queue resets also move the tap machine. Throughput is one
// transaction per clock unless out_ready stalls: the input register feeds a single pass of
// logic (a handful of 32-bit subtract-and-compare timers, the phase machine and the queue
// pointers) into the result register, and a new input transaction is taken in the same
// cycle that the previous one moves into the result register, even while the result
// register is being emptied. Each transaction passes from the input register into the
// result register, which raises out_valid. Events wait in a QUEUE_DEPTH-entry RAM with a
// registered read port that always prefetches the next head entry, so no clearing pass is
// needed after reset. The configuration port takes a write in any cycle but must only be
// used while no transaction is in flight; changing direct_mode discards a pending select tap.
module button_gesture_decoder_core #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [15:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         operation,
	input  logic [31:0]                        time_ms,
	input  logic                               next_level,
	input  logic                               prev_level,
	input  logic                               next_press,
	input  logic                               prev_press,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         event_code,
	output logic                               beep,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queued_count
);
	import bgd_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cfg_t             cfg_q;
	logic             mode_flip;
	logic             valid_s1;
	item_t            item_s1;
	logic             fire;
	logic             out_valid_q;
	logic [2:0]       event_code_q;
	logic             beep_q;
	logic [CNT_W-1:0] count_q;
	q_cmd_t           q_cmd;
	logic [2:0]       q_head;
	logic             q_empty;
	logic [CNT_W-1:0] q_count_nxt;
	logic [2:0]       res_code;
	logic             res_beep;

	// The item in the input register is processed when the result register can take it.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// A direct_mode write that changes the mode drops any pending tap.
	assign mode_flip = cfg_we && (reg_idx_t'(cfg_index) == REG_DIRECT_MODE)
	                   && (cfg_data[0] != cfg_q.direct_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direct_mode       <= 1'b0;
			cfg_q.double_tap_window <= DOUBLE_TAP_RESET;
			cfg_q.long_press_time   <= LONG_PRESS_RESET;
			cfg_q.combo_tolerance   <= COMBO_TOLERANCE_RESET;
			cfg_q.repeat_initial    <= REPEAT_INITIAL_RESET;
			cfg_q.repeat_interval   <= REPEAT_INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIRECT_MODE:     cfg_q.direct_mode       <= cfg_data[0];
				REG_DOUBLE_TAP:      cfg_q.double_tap_window <= cfg_data;
				REG_LONG_PRESS:      cfg_q.long_press_time   <= cfg_data;
				REG_COMBO_TOLERANCE: cfg_q.combo_tolerance   <= cfg_data;
				REG_REPEAT_INITIAL:  cfg_q.repeat_initial    <= cfg_data;
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval   <= cfg_data;
				default:             cfg_q                   <= cfg_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{op: operation, time_ms: time_ms, next_level: next_level,
			             prev_level: prev_level, next_press: next_press,
			             prev_press: prev_press};
		end
	end

	bgd_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg      (cfg_q),
		.mode_flip(mode_flip),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_cmd    (q_cmd),
		.res_code (res_code),
		.res_beep (res_beep)
	);

	bgd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.head     (q_head),
		.empty    (q_empty),
		.count_nxt(q_count_nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			event_code_q <= res_code;
			beep_q       <= res_beep;
			count_q      <= q_count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = event_code_q;
	assign beep         = beep_q;
	assign queued_count = count_q;

`include "assert_macros.svh"

	`AST_CHK(a_count_bound, out_valid_q |-> (count_q <= CNT_W'(QUEUE_DEPTH)), "queue count above depth")
	`AST_CHK(a_beep_long, (out_valid_q && beep_q) |-> (event_code_q == EV_LONG || event_code_q == EV_NONE), "beep without long select")
	`AST_CHK(a_pop_event, (fire && item_s1.op == OP_POLL && !q_empty) |=> (event_code_q != EV_NONE), "pop of nonempty queue gave no event")
	`AST_NEVER(a_ready_free, !out_valid_q && !in_ready, "input stalled while result register is empty")

endmodule
